// ----- hw/rtl/ate_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ate_pkg;

  // Field widths fixed by the port list
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int CLR_W   = 3;
  localparam int CHAR_W  = 8;
  localparam int CELL_W  = CHAR_W + 2 * CLR_W;
  localparam int PARAM_W = 10;
  localparam int CFG_W   = 7;

  localparam int DEF_MAX_COLS = 80;
  localparam int DEF_MAX_ROWS = 25;

  localparam logic [PARAM_W-1:0] PARAM_MAX = 10'd1023;

  // Byte codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_J     = 8'h4A;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_SHOW  = 8'h68;
  localparam logic [7:0] CH_HIDE  = 8'h6C;

  localparam logic [PARAM_W-1:0] P_CURSOR = 10'd25;

  localparam logic [CLR_W-1:0] CLR_GREY  = 3'd7;
  localparam logic [CLR_W-1:0] CLR_BLACK = 3'd0;

  typedef enum logic [1:0] {
    CFG_COLUMNS = 2'd0,
    CFG_ROWS    = 2'd1,
    CFG_NL_RET  = 2'd2
  } cfg_idx_t;

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
  endfunction

  function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] ch,
                                                  input logic [CLR_W-1:0] fg,
                                                  input logic [CLR_W-1:0] bg);
    return {bg, fg, ch};
  endfunction

  // Cursor position from a 1-based parameter, clamped to the area in use
  function automatic logic [COL_W-1:0] clamp_pos(input logic seen,
                                                 input logic [PARAM_W-1:0] p,
                                                 input logic [COL_W-1:0] lim);
    logic [PARAM_W-1:0] pm1;
    pm1 = p - 10'd1;
    if (!seen || (p == '0)) return '0;
    if (pm1 >= {3'b000, lim}) return lim - 7'd1;
    return pm1[COL_W-1:0];
  endfunction

  // One SGR parameter applied to {fg, bg}
  function automatic logic [2*CLR_W-1:0] apply_sgr(input logic [PARAM_W-1:0] p,
                                                   input logic [2*CLR_W-1:0] c);
    logic [CLR_W-1:0] fg;
    logic [CLR_W-1:0] bg;
    logic [PARAM_W-1:0] d;
    fg = c[2*CLR_W-1:CLR_W];
    bg = c[CLR_W-1:0];
    if (p == 10'd0) begin
      fg = CLR_GREY;
      bg = CLR_BLACK;
    end else if (p == 10'd7) begin
      fg = c[CLR_W-1:0];
      bg = c[2*CLR_W-1:CLR_W];
    end else if ((p >= 10'd30) && (p <= 10'd37)) begin
      d  = p - 10'd30;
      fg = d[CLR_W-1:0];
    end else if (p == 10'd39) begin
      fg = CLR_GREY;
    end else if ((p >= 10'd40) && (p <= 10'd47)) begin
      d  = p - 10'd40;
      bg = d[CLR_W-1:0];
    end else if (p == 10'd49) begin
      bg = CLR_BLACK;
    end
    return {fg, bg};
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ate_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ate_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 2000,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ansi_text_terminal_engine_core.sv -----
// Text terminal engine: a character store of MAX_ROWS x MAX_COLS cells plus
// cursor, colors and an escape parser.
// Input channel (in_valid/in_ready): each request carries in_op. Op 0 feeds
// in_data_byte to the terminal, op 1 reads the cell at in_read_row/in_read_col.
// Output channel (out_valid/out_ready): one result per request with cursor,
// visibility, current colors and, for a read, the cell contents.
// One request is worked at a time; in_ready drops from acceptance until its
// result has been loaded into the output register. A waiting result does not
// block acceptance of the next request.
// Scrolling copies the store through the single RAM port pair, reading each
// cell in S_COPY_RD and writing it one row up in S_COPY_WR, then blanks the
// bottom row. Erase in line and clear screen write one cell per cycle.
// After reset the store is cleared to grey-on-black blanks, one cell a cycle,
// with in_ready low; configuration writes are taken during that pass. When the
// receiver stalls, a finished result waits in the output register, and the
// next one waits in the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module ansi_text_terminal_engine_core
  import ate_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_op,
  input  wire logic [CHAR_W-1:0] in_data_byte,
  input  wire logic [ROW_W-1:0]  in_read_row,
  input  wire logic [COL_W-1:0]  in_read_col,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [ROW_W-1:0]       out_cursor_row,
  output logic [COL_W-1:0]       out_cursor_col,
  output logic                   out_cursor_shown,
  output logic [CLR_W-1:0]       out_fg_color,
  output logic [CLR_W-1:0]       out_bg_color,
  output logic [CHAR_W-1:0]      out_cell_char,
  output logic [CLR_W-1:0]       out_cell_fg,
  output logic [CLR_W-1:0]       out_cell_bg
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [9:0] {
    S_CLEAR   = 10'b00_0000_0001,
    S_IDLE    = 10'b00_0000_0010,
    S_FEED    = 10'b00_0000_0100,
    S_READ    = 10'b00_0000_1000,
    S_RWAIT   = 10'b00_0001_0000,
    S_COPY_RD = 10'b00_0010_0000,
    S_COPY_WR = 10'b00_0100_0000,
    S_BLANK   = 10'b00_1000_0000,
    S_WRITE   = 10'b01_0000_0000,
    S_DONE    = 10'b10_0000_0000
  } state_t;

  typedef enum logic [4:0] {
    PH_TEXT  = 5'b00001,
    PH_ESC   = 5'b00010,
    PH_SKIP  = 5'b00100,
    PH_CSI   = 5'b01000,
    PH_PARAM = 5'b10000
  } phase_t;

  function automatic logic [AW-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                              input logic [COL_W-1:0] c);
    return AW'(AW'(r) * AW'(MAX_COLS)) + AW'(c);
  endfunction

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic              op_r;
  logic [CHAR_W-1:0] byte_r;
  logic [ROW_W-1:0]  rrow_r;
  logic [COL_W-1:0]  rcol_r;

  logic [ROW_W-1:0]   cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]   cur_col_r, cur_col_nxt;
  logic [PARAM_W-1:0] param_r [3];
  logic [PARAM_W-1:0] param_nxt [3];
  logic [1:0]         pidx_r, pidx_nxt;
  logic [2:0]         pseen_r, pseen_nxt;
  logic               q_r, q_nxt;
  logic [CLR_W-1:0]   fg_r, fg_nxt;
  logic [CLR_W-1:0]   bg_r, bg_nxt;
  logic               vis_r, vis_nxt;
  logic               wr_pend_r, wr_pend_nxt;

  logic [COL_W-1:0] cfg_cols_r;
  logic [ROW_W-1:0] cfg_rows_r;
  logic             cfg_nl_r;

  logic [ROW_W-1:0] sw_row_r, sw_row_nxt;
  logic [COL_W-1:0] sw_col_r, sw_col_nxt;
  logic [COL_W-1:0] sw_c0_r, sw_c0_nxt;
  logic [COL_W-1:0] sw_c1_r, sw_c1_nxt;
  logic [ROW_W-1:0] sw_rlast_r, sw_rlast_nxt;
  logic [AW-1:0]    clr_r;
  logic [CELL_W-1:0] cell_r, cell_nxt;

  logic              out_valid_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;
  logic              out_vis_r;
  logic [CLR_W-1:0]  out_fg_r;
  logic [CLR_W-1:0]  out_bg_r;
  logic [CELL_W-1:0] out_cell_r;
  logic              out_load;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  logic [COL_W-1:0] cols_eff;
  logic [ROW_W-1:0] rows_eff;
  logic [ROW_W-1:0] row_e;
  logic [ROW_W-1:0] row_last;
  logic             is_digit;
  logic [13:0]      acc;
  logic [PARAM_W-1:0] acc_sat;
  logic [2*CLR_W-1:0] sgr0, sgr1, sgr2;
  logic [COL_W-1:0] h_row;
  logic             lf_req;
  logic             wr_req;
  logic             sw_last_col;
  logic             sw_last_row;

  ate_ram #(
    .WIDTH(CELL_W),
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Clamp configured size to the store
  always_comb begin
    if (cfg_cols_r == '0) begin
      cols_eff = COL_W'(1);
    end else if (int'(cfg_cols_r) > MAX_COLS) begin
      cols_eff = COL_W'(MAX_COLS);
    end else begin
      cols_eff = cfg_cols_r;
    end
    if (cfg_rows_r == '0) begin
      rows_eff = ROW_W'(1);
    end else if (int'(cfg_rows_r) > MAX_ROWS) begin
      rows_eff = ROW_W'(MAX_ROWS);
    end else begin
      rows_eff = cfg_rows_r;
    end
  end

  assign row_e    = (cur_row_r >= rows_eff) ? '0 : cur_row_r;
  assign row_last = rows_eff - 5'd1;
  assign is_digit = (byte_r >= CH_ZERO) && (byte_r <= CH_NINE);

  // Decimal accumulate, saturating
  assign acc     = {param_r[pidx_r], 3'b000} + {3'b000, param_r[pidx_r], 1'b0}
                 + {6'd0, byte_r - CH_ZERO};
  assign acc_sat = (acc > {4'd0, PARAM_MAX}) ? PARAM_MAX : acc[PARAM_W-1:0];

  // SGR chain over the present parameters
  assign sgr0  = pseen_r[0] ? apply_sgr(param_r[0], {fg_r, bg_r}) : {fg_r, bg_r};
  assign sgr1  = pseen_r[1] ? apply_sgr(param_r[1], sgr0) : sgr0;
  assign sgr2  = pseen_r[2] ? apply_sgr(param_r[2], sgr1) : sgr1;
  assign h_row = clamp_pos(1'b1, param_r[0], {2'b00, rows_eff});

  assign sw_last_col = (sw_col_r + 7'd1) >= sw_c1_r;
  assign sw_last_row = (sw_row_r == sw_rlast_r);

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    cur_row_nxt  = cur_row_r;
    cur_col_nxt  = cur_col_r;
    param_nxt    = param_r;
    pidx_nxt     = pidx_r;
    pseen_nxt    = pseen_r;
    q_nxt        = q_r;
    fg_nxt       = fg_r;
    bg_nxt       = bg_r;
    vis_nxt      = vis_r;
    wr_pend_nxt  = wr_pend_r;
    sw_row_nxt   = sw_row_r;
    sw_col_nxt   = sw_col_r;
    sw_c0_nxt    = sw_c0_r;
    sw_c1_nxt    = sw_c1_r;
    sw_rlast_nxt = sw_rlast_r;
    cell_nxt     = cell_r;
    ram_we       = 1'b0;
    ram_waddr    = clr_r;
    ram_wdata    = make_cell(CH_SPACE, CLR_GREY, CLR_BLACK);
    ram_raddr    = cell_addr(rrow_r, rcol_r);
    lf_req       = 1'b0;
    wr_req       = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          cell_nxt  = '0;
          state_nxt = in_op ? S_READ : S_FEED;
        end
      end

      S_READ: begin
        if ((int'(rrow_r) < MAX_ROWS) && (int'(rcol_r) < MAX_COLS)) begin
          state_nxt = S_RWAIT;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_RWAIT: begin
        cell_nxt  = ram_rdata;
        state_nxt = S_DONE;
      end

      S_FEED: begin
        cur_row_nxt = row_e;
        state_nxt   = S_DONE;
        unique case (phase_r) inside
          PH_ESC: begin
            if (byte_r == CH_LBRK) begin
              phase_nxt = PH_CSI;
              param_nxt = '{default: '0};
              pidx_nxt  = '0;
              pseen_nxt = 3'b001;
              q_nxt     = 1'b0;
            end else begin
              phase_nxt = is_letter(byte_r) ? PH_TEXT : PH_SKIP;
            end
          end
          PH_SKIP: begin
            if (is_letter(byte_r)) begin
              phase_nxt = PH_TEXT;
            end
          end
          PH_CSI, PH_PARAM: begin
            phase_nxt = PH_PARAM;
            if ((phase_r == PH_CSI) && (byte_r == CH_QMARK)) begin
              q_nxt = 1'b1;
            end else if (is_digit) begin
              param_nxt[pidx_r] = acc_sat;
            end else if ((byte_r == CH_SEMI) && (pidx_r < 2'd2)) begin
              pidx_nxt  = pidx_r + 2'd1;
              pseen_nxt = pseen_r | (3'b001 << (pidx_r + 2'd1));
            end else begin
              // Final byte
              phase_nxt = PH_TEXT;
              if (q_r && (param_r[0] == P_CURSOR)) begin
                if (byte_r == CH_HIDE) vis_nxt = 1'b0;
                if (byte_r == CH_SHOW) vis_nxt = 1'b1;
              end
              if (byte_r == CH_H) begin
                cur_row_nxt = h_row[ROW_W-1:0];
                cur_col_nxt = clamp_pos(pseen_r[1], param_r[1], cols_eff);
              end else if (byte_r == CH_K) begin
                if (param_r[0] == '0) begin
                  sw_row_nxt   = row_e;
                  sw_col_nxt   = cur_col_r;
                  sw_c0_nxt    = cur_col_r;
                  sw_c1_nxt    = cols_eff;
                  sw_rlast_nxt = row_e;
                  state_nxt    = S_BLANK;
                end
              end else if (byte_r == CH_J) begin
                if (param_r[0] == 10'd2) begin
                  sw_row_nxt   = '0;
                  sw_col_nxt   = '0;
                  sw_c0_nxt    = '0;
                  sw_c1_nxt    = cols_eff;
                  sw_rlast_nxt = row_last;
                  state_nxt    = S_BLANK;
                end
              end else if (byte_r == CH_M) begin
                fg_nxt = sgr2[2*CLR_W-1:CLR_W];
                bg_nxt = sgr2[CLR_W-1:0];
              end
            end
          end
          default: begin
            phase_nxt = PH_TEXT;
            if (byte_r == CH_NUL) begin
              state_nxt = S_DONE;
            end else if (byte_r == CH_ESC) begin
              phase_nxt = PH_ESC;
            end else if (byte_r == CH_CR) begin
              cur_col_nxt = '0;
            end else if (byte_r == CH_LF) begin
              if (cfg_nl_r) cur_col_nxt = '0;
              lf_req = 1'b1;
            end else begin
              wr_req = 1'b1;
              if (cur_col_r >= cols_eff) begin
                cur_col_nxt = '0;
                lf_req      = 1'b1;
              end
            end
          end
        endcase
        wr_pend_nxt = wr_req;
        if (wr_req) begin
          state_nxt = S_WRITE;
        end
        // Line feed, scrolling at the bottom
        if (lf_req) begin
          if (row_e == row_last) begin
            cur_row_nxt  = row_last;
            sw_col_nxt   = '0;
            sw_c0_nxt    = '0;
            sw_c1_nxt    = cols_eff;
            if (rows_eff >= 5'd2) begin
              sw_row_nxt   = '0;
              sw_rlast_nxt = rows_eff - 5'd2;
              state_nxt    = S_COPY_RD;
            end else begin
              sw_row_nxt   = row_last;
              sw_rlast_nxt = row_last;
              state_nxt    = S_BLANK;
            end
          end else begin
            cur_row_nxt = row_e + 5'd1;
          end
        end
      end

      S_COPY_RD: begin
        ram_raddr = cell_addr(sw_row_r + 5'd1, sw_col_r);
        state_nxt = S_COPY_WR;
      end

      S_COPY_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr(sw_row_r, sw_col_r);
        ram_wdata = ram_rdata;
        state_nxt = S_COPY_RD;
        if (sw_last_col) begin
          sw_col_nxt = sw_c0_r;
          if (sw_last_row) begin
            sw_row_nxt   = row_last;
            sw_rlast_nxt = row_last;
            state_nxt    = S_BLANK;
          end else begin
            sw_row_nxt = sw_row_r + 5'd1;
          end
        end else begin
          sw_col_nxt = sw_col_r + 7'd1;
        end
      end

      S_BLANK: begin
        ram_waddr = cell_addr(sw_row_r, sw_col_r);
        ram_wdata = make_cell(CH_SPACE, fg_r, bg_r);
        if (sw_col_r < sw_c1_r) begin
          ram_we = 1'b1;
        end
        if ((sw_col_r >= sw_c1_r) || (sw_last_col && sw_last_row)) begin
          state_nxt = wr_pend_r ? S_WRITE : S_DONE;
        end else if (sw_last_col) begin
          sw_col_nxt = sw_c0_r;
          sw_row_nxt = sw_row_r + 5'd1;
        end else begin
          sw_col_nxt = sw_col_r + 7'd1;
        end
      end

      S_WRITE: begin
        ram_we      = 1'b1;
        ram_waddr   = cell_addr(cur_row_r, cur_col_r);
        ram_wdata   = make_cell(byte_r, fg_r, bg_r);
        cur_col_nxt = cur_col_r + 7'd1;
        wr_pend_nxt = 1'b0;
        state_nxt   = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and terminal state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      phase_r     <= PH_TEXT;
      clr_r       <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      param_r     <= '{default: '0};
      pidx_r      <= '0;
      pseen_r     <= '0;
      q_r         <= 1'b0;
      fg_r        <= CLR_GREY;
      bg_r        <= CLR_BLACK;
      vis_r       <= 1'b1;
      wr_pend_r   <= 1'b0;
      cfg_cols_r  <= COL_W'(80);
      cfg_rows_r  <= ROW_W'(25);
      cfg_nl_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      param_r   <= param_nxt;
      pidx_r    <= pidx_nxt;
      pseen_r   <= pseen_nxt;
      q_r       <= q_nxt;
      fg_r      <= fg_nxt;
      bg_r      <= bg_nxt;
      vis_r     <= vis_nxt;
      wr_pend_r <= wr_pend_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (cfg_wr_en) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_COLUMNS: cfg_cols_r <= cfg_data;
          CFG_ROWS:    cfg_rows_r <= cfg_data[ROW_W-1:0];
          CFG_NL_RET:  cfg_nl_r   <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request payload, sweep counters and result register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r   <= in_op;
      byte_r <= in_data_byte;
      rrow_r <= in_read_row;
      rcol_r <= in_read_col;
    end
    sw_row_r   <= sw_row_nxt;
    sw_col_r   <= sw_col_nxt;
    sw_c0_r    <= sw_c0_nxt;
    sw_c1_r    <= sw_c1_nxt;
    sw_rlast_r <= sw_rlast_nxt;
    cell_r     <= cell_nxt;
    if (out_load) begin
      out_row_r  <= cur_row_r;
      out_col_r  <= cur_col_r;
      out_vis_r  <= vis_r;
      out_fg_r   <= fg_r;
      out_bg_r   <= bg_r;
      out_cell_r <= op_r ? cell_r : '0;
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_cursor_row   = out_row_r;
  assign out_cursor_col   = out_col_r;
  assign out_cursor_shown = out_vis_r;
  assign out_fg_color     = out_fg_r;
  assign out_bg_color     = out_bg_r;
  assign out_cell_char    = out_cell_r[CHAR_W-1:0];
  assign out_cell_fg      = out_cell_r[CHAR_W+CLR_W-1:CHAR_W];
  assign out_cell_bg      = out_cell_r[CELL_W-1:CHAR_W+CLR_W];

endmodule

`default_nettype wire

// ----- hw/rtl/ate_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ate_checker
  import ate_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [ROW_W-1:0] out_cursor_row,
  input wire logic [COL_W-1:0] out_cursor_col
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // One request in flight: no acceptance right after an acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted back to back");

  // A stalled result is held
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("stalled result dropped");

  // Cursor row stays inside the default store; the column may sit one past its last column
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((int'(out_cursor_row) < DEF_MAX_ROWS)
                   && (int'(out_cursor_col) <= DEF_MAX_COLS)))
    else $error("cursor outside the store");

endmodule

bind ansi_text_terminal_engine_core ate_checker u_ate_checker (.*);

`default_nettype wire

// ----- sim/ansi_text_terminal_engine_core_tb.sv -----
`timescale 1ns / 1ps

module ansi_text_terminal_engine_core_tb;
  import ate_pkg::*;

  localparam int NCOLS = DEF_MAX_COLS;
  localparam int NROWS = DEF_MAX_ROWS;
  localparam int CYCLE_LIMIT = 20000000;

  typedef struct {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              shown;
    logic [CLR_W-1:0]  fg;
    logic [CLR_W-1:0]  bg;
    logic [CHAR_W-1:0] ch;
    logic [CLR_W-1:0]  cfg;
    logic [CLR_W-1:0]  cbg;
  } screen_status_t;

  typedef enum int {PS_TEXT, PS_ESC, PS_SKIP, PS_CSI, PS_PARAM} parse_state_t;

  // Terminal predictor plus queue of pending status words
  class terminal_scoreboard;
    logic [CELL_W-1:0] cells [NROWS][NCOLS];
    int crow, ccol;
    parse_state_t pstate;
    int prm [3];
    int pidx, pseen;
    bit qmark;
    logic [CLR_W-1:0] fgc, bgc;
    bit shown;
    int reg_cols, reg_rows, reg_nlr;
    screen_status_t pending_q [$];
    int errors;
    int checked;

    function void reset_state();
      for (int r = 0; r < NROWS; r++)
        for (int c = 0; c < NCOLS; c++) cells[r][c] = {CLR_BLACK, CLR_GREY, CH_SPACE};
      crow = 0; ccol = 0; pstate = PS_TEXT;
      prm[0] = 0; prm[1] = 0; prm[2] = 0;
      pidx = 0; pseen = 0; qmark = 0;
      fgc = CLR_GREY; bgc = CLR_BLACK; shown = 1;
      reg_cols = 80; reg_rows = 25; reg_nlr = 1;
    endfunction

    function void set_reg(cfg_idx_t idx, int val);
      case (idx)
        CFG_COLUMNS: reg_cols = val & 8'h7F;
        CFG_ROWS:    reg_rows = val & 8'h1F;
        CFG_NL_RET:  reg_nlr = val & 1;
        default: ;
      endcase
    endfunction

    function int used_cols();
      return (reg_cols < 1) ? 1 : (reg_cols > NCOLS) ? NCOLS : reg_cols;
    endfunction

    function int used_rows();
      return (reg_rows < 1) ? 1 : (reg_rows > NROWS) ? NROWS : reg_rows;
    endfunction

    function bit is_alpha(logic [7:0] b);
      return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function void blank_span(int r, int from, int to);
      if (r >= NROWS) return;
      for (int c = from; c < to && c < NCOLS; c++) cells[r][c] = {bgc, fgc, CH_SPACE};
    endfunction

    function void line_feed(bit to_col0);
      int er, ec;
      er = used_rows();
      ec = used_cols();
      if (to_col0) ccol = 0;
      crow++;
      // scroll up one row at the bottom
      if (crow >= er) begin
        for (int r = 0; r + 1 < er; r++)
          for (int c = 0; c < ec; c++) cells[r][c] = cells[r+1][c];
        blank_span(er - 1, 0, ec);
        crow = er - 1;
      end
    endfunction

    function int clamp_pos(bit seen, int p, int lim);
      if (!seen || p == 0) return 0;
      if (p - 1 >= lim) return lim - 1;
      return p - 1;
    endfunction

    function void apply_color(int p);
      logic [CLR_W-1:0] t;
      if (p == 0) begin
        fgc = CLR_GREY; bgc = CLR_BLACK;
      end else if (p == 7) begin
        t = fgc; fgc = bgc; bgc = t;
      end else if (p >= 30 && p <= 37) begin
        fgc = p - 30;
      end else if (p == 39) begin
        fgc = CLR_GREY;
      end else if (p >= 40 && p <= 47) begin
        bgc = p - 40;
      end else if (p == 49) begin
        bgc = CLR_BLACK;
      end
    endfunction

    function void run_command(logic [7:0] b);
      if (qmark && prm[0] == P_CURSOR) begin
        if (b == CH_HIDE) shown = 0;
        if (b == CH_SHOW) shown = 1;
      end
      if (b == CH_H) begin
        crow = clamp_pos(1, prm[0], used_rows());
        ccol = clamp_pos(pseen[1], prm[1], used_cols());
      end else if (b == CH_K) begin
        if (prm[0] == 0) blank_span(crow, ccol, used_cols());
      end else if (b == CH_J) begin
        if (prm[0] == 2)
          for (int i = 0; i < used_rows(); i++) blank_span(i, 0, used_cols());
      end else if (b == CH_M) begin
        for (int i = 0; i < 3; i++) if (pseen[i]) apply_color(prm[i]);
      end
    endfunction

    function void feed_byte(logic [7:0] b);
      int v;
      if (crow >= used_rows()) crow = 0;
      case (pstate)
        PS_ESC: begin
          if (b == CH_LBRK) begin
            pstate = PS_CSI;
            prm[0] = 0; prm[1] = 0; prm[2] = 0;
            pidx = 0; pseen = 1; qmark = 0;
          end else begin
            pstate = is_alpha(b) ? PS_TEXT : PS_SKIP;
          end
          return;
        end
        PS_SKIP: begin
          if (is_alpha(b)) pstate = PS_TEXT;
          return;
        end
        PS_CSI, PS_PARAM: begin
          if (pstate == PS_CSI && b == CH_QMARK) begin
            pstate = PS_PARAM;
            qmark = 1;
            return;
          end
          pstate = PS_PARAM;
          if (b >= CH_ZERO && b <= CH_NINE) begin
            v = prm[pidx] * 10 + (b - CH_ZERO);
            prm[pidx] = (v > PARAM_MAX) ? PARAM_MAX : v;
          end else if (b == CH_SEMI && pidx < 2) begin
            pidx++;
            pseen |= 1 << pidx;
          end else begin
            run_command(b);
            pstate = PS_TEXT;
          end
          return;
        end
        default: ;
      endcase
      pstate = PS_TEXT;
      if (b == CH_NUL) return;
      if (b == CH_ESC) begin
        pstate = PS_ESC;
        return;
      end
      if (b == CH_CR) begin
        ccol = 0;
        return;
      end
      if (b == CH_LF) begin
        line_feed(reg_nlr != 0);
        return;
      end
      // wrap first, then print at the cursor
      if (ccol >= used_cols()) line_feed(1);
      cells[crow][ccol] = {bgc, fgc, b};
      ccol++;
    endfunction

    function void note_request(logic op, logic [7:0] b, logic [ROW_W-1:0] r,
                               logic [COL_W-1:0] c);
      screen_status_t s;
      logic [CELL_W-1:0] rd_cell;
      rd_cell = '0;
      if (!op) feed_byte(b);
      else if (r < NROWS && c < NCOLS) rd_cell = cells[r][c];
      s.row = crow;
      s.col = ccol;
      s.shown = shown;
      s.fg = fgc;
      s.bg = bgc;
      s.ch = rd_cell[CHAR_W-1:0];
      s.cfg = rd_cell[CHAR_W +: CLR_W];
      s.cbg = rd_cell[CHAR_W+CLR_W +: CLR_W];
      pending_q.push_back(s);
    endfunction

    function void check_result(screen_status_t a);
      screen_status_t e;
      if (pending_q.size() == 0) begin
        $error("status word with no request waiting");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (a.row !== e.row) begin
        $error("cursor_row: expected %0d, got %0d", e.row, a.row); errors++;
      end
      if (a.col !== e.col) begin
        $error("cursor_col: expected %0d, got %0d", e.col, a.col); errors++;
      end
      if (a.shown !== e.shown) begin
        $error("cursor_shown: expected %0d, got %0d", e.shown, a.shown); errors++;
      end
      if (a.fg !== e.fg) begin
        $error("fg_color: expected %0d, got %0d", e.fg, a.fg); errors++;
      end
      if (a.bg !== e.bg) begin
        $error("bg_color: expected %0d, got %0d", e.bg, a.bg); errors++;
      end
      if (a.ch !== e.ch) begin
        $error("cell_char: expected %0d, got %0d", e.ch, a.ch); errors++;
      end
      if (a.cfg !== e.cfg) begin
        $error("cell_fg: expected %0d, got %0d", e.cfg, a.cfg); errors++;
      end
      if (a.cbg !== e.cbg) begin
        $error("cell_bg: expected %0d, got %0d", e.cbg, a.cbg); errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [1:0]        cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic              in_op;
  logic [CHAR_W-1:0] in_data_byte;
  logic [ROW_W-1:0]  in_read_row;
  logic [COL_W-1:0]  in_read_col;
  logic              out_valid;
  logic              out_ready;
  logic [ROW_W-1:0]  out_cursor_row;
  logic [COL_W-1:0]  out_cursor_col;
  logic              out_cursor_shown;
  logic [CLR_W-1:0]  out_fg_color;
  logic [CLR_W-1:0]  out_bg_color;
  logic [CHAR_W-1:0] out_cell_char;
  logic [CLR_W-1:0]  out_cell_fg;
  logic [CLR_W-1:0]  out_cell_bg;

  terminal_scoreboard sb;
  bit quiet;
  bit stall_go;
  int requests_sent;
  int settings_used;

  ansi_text_terminal_engine_core uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_data_byte(in_data_byte), .in_read_row(in_read_row), .in_read_col(in_read_col),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_cursor_row(out_cursor_row), .out_cursor_col(out_cursor_col),
    .out_cursor_shown(out_cursor_shown), .out_fg_color(out_fg_color),
    .out_bg_color(out_bg_color), .out_cell_char(out_cell_char),
    .out_cell_fg(out_cell_fg), .out_cell_bg(out_cell_bg)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("DONE: errors detected");
    $finish;
  end

  // Receive status words; random back-pressure and one long hold-off
  initial begin
    screen_status_t a;
    int hold_left;
    bit seen_go;
    hold_left = 0;
    seen_go = 0;
    out_ready = 1;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        a.row = out_cursor_row; a.col = out_cursor_col; a.shown = out_cursor_shown;
        a.fg = out_fg_color; a.bg = out_bg_color; a.ch = out_cell_char;
        a.cfg = out_cell_fg; a.cbg = out_cell_bg;
        sb.check_result(a);
      end
      @(negedge clk);
      if (stall_go != seen_go) begin
        seen_go = stall_go;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 0;
      end else begin
        out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 8);
      end
    end
  end

  // Present one request and hold it until taken
  task automatic send_req(logic op, logic [7:0] b, logic [ROW_W-1:0] r,
                          logic [COL_W-1:0] c);
    if (!quiet && $urandom_range(0, 99) < 8) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1;
    in_op <= op;
    in_data_byte <= b;
    in_read_row <= r;
    in_read_col <= c;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op, b, r, c);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_req(1'b0, b, $urandom_range(0, 31), $urandom_range(0, 127));
  endtask

  task automatic send_read(int r, int c);
    send_req(1'b1, $urandom_range(0, 255), r, c);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic write_reg(cfg_idx_t idx, int val);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_wr_en <= 0;
    @(negedge clk);
  endtask

  // Drop valid and let all results drain
  task automatic drain();
    in_valid <= 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // Random CSI sequence, with occasional overflow, fourth parameter or odd final
  task automatic send_csi();
    int n, v;
    logic [7:0] finals [7];
    finals = '{CH_H, CH_K, CH_J, CH_M, CH_SHOW, CH_HIDE, 8'h00};
    finals[6] = $urandom_range(0, 255);
    send_byte(CH_ESC);
    send_byte(CH_LBRK);
    if ($urandom_range(0, 3) == 0) send_byte(CH_QMARK);
    n = $urandom_range(0, 9) == 0 ? 4 : $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      if (i > 0) send_byte(CH_SEMI);
      case ($urandom_range(0, 5))
        0: v = -1;
        1: v = 25;
        2: v = $urandom_range(0, 9);
        3: v = $urandom_range(30, 49);
        4: v = $urandom_range(0, 99);
        default: v = $urandom_range(1000, 99999);
      endcase
      if (v >= 0) send_text($sformatf("%0d", v));
    end
    send_byte(finals[$urandom_range(0, 6)]);
  endtask

  task automatic send_random_piece();
    int k;
    k = $urandom_range(0, 99);
    if (k < 35) begin
      repeat ($urandom_range(1, 8)) send_byte($urandom_range(8'h20, 8'h7E));
    end else if (k < 45) begin
      send_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
    end else if (k < 70) begin
      send_csi();
    end else if (k < 75) begin
      // non-CSI escape skipped up to a letter
      send_byte(CH_ESC);
      repeat ($urandom_range(0, 3)) send_byte($urandom_range(8'h21, 8'h40));
      send_byte($urandom_range(8'h61, 8'h7A));
    end else if (k < 95) begin
      if ($urandom_range(0, 4) == 0) send_read($urandom_range(0, 31), $urandom_range(0, 127));
      else send_read($urandom_range(0, sb.used_rows() - 1),
                     $urandom_range(0, sb.used_cols() - 1));
    end else begin
      send_byte($urandom_range(0, 255));
    end
  endtask

  initial begin
    int phase_cols [7];
    int phase_rows [7];
    int phase_nlr [7];
    int phase_items [7];
    int start;
    phase_cols = '{80, 10, 1, 0, 127, 20, 80};
    phase_rows = '{25, 4, 2, 0, 31, 25, 3};
    phase_nlr = '{1, 0, 1, 0, 1, 0, 1};
    phase_items = '{90, 100, 60, 50, 60, 80, 60};
    sb = new();
    sb.reset_state();
    sb.errors = 0;
    sb.checked = 0;
    quiet = 0;
    stall_go = 0;
    requests_sent = 0;
    settings_used = 0;
    rst_n = 0;
    cfg_wr_en = 0;
    cfg_index = CFG_COLUMNS;
    cfg_data = '0;
    in_valid = 0;
    in_op = 0;
    in_data_byte = '0;
    in_read_row = '0;
    in_read_col = '0;

    // Hold reset, then release at a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: extremes, controls and each command
    send_read(0, 0);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(CH_NUL);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_text("\033[?25l");
    send_text("\033[?25h");
    send_text("\033[5;10H");
    send_text("\033[31;47;7m");
    send_text("\033[99999;0H");
    send_text("\033[K\033[2J");
    send_text("\033(xB\033[0m");
    send_read(24, 79);
    send_read(31, 127);
    send_read(25, 0);
    send_read(0, 80);
    drain();

    for (int p = 0; p < 7; p++) begin
      write_reg(CFG_COLUMNS, phase_cols[p]);
      write_reg(CFG_ROWS, phase_rows[p]);
      write_reg(CFG_NL_RET, phase_nlr[p]);
      settings_used++;
      quiet = (p == 5);
      start = requests_sent;
      while (requests_sent - start < phase_items[p]) begin
        // long receiver hold-off while requests keep coming
        if (p == 1 && !stall_go && requests_sent - start >= 20) stall_go = 1;
        send_random_piece();
      end
      drain();
    end
    quiet = 0;

    $display("Covered %0d requests (%0d status words checked) over %0d register settings,",
             requests_sent, sb.checked, settings_used);
    $display("including text, wrap, scroll, CSI commands, skipped escapes and reads.");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/ate_pkg.sv
hw/rtl/ate_ram.sv
hw/rtl/ansi_text_terminal_engine_core.sv
hw/rtl/ate_checker.sv
sim/ansi_text_terminal_engine_core_tb.sv
